@@ rtl/core/utf8d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int PEND_W = 2;

    localparam logic [CP_W-1:0] MAX_CP_RESET = 21'h10FFFF;

    // Payload masks for the lead bytes and for continuation bytes.
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THR  = 2'd3;

    typedef struct packed {
        logic [PEND_W-1:0] pending;
        logic [CP_W-1:0]   partial;
        logic              err;
    } t_dec_state;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            point_valid;
        logic            error_flag;
    } t_dec_result;

endpackage

`default_nettype wire

@@ rtl/core/utf8d_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module utf8d_step (
    input  wire utf8d_pkg::t_dec_state        i_state,
    input  wire logic [utf8d_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                         i_last,
    input  wire logic [utf8d_pkg::CP_W-1:0]   i_max_cp,
    output utf8d_pkg::t_dec_state             o_state,
    output utf8d_pkg::t_dec_result            o_result
);

    utf8d_pkg::t_dec_state n_st;
    logic                  bad;
    logic                  lead_ok;

    always_comb begin
        n_st               = i_state;
        bad                = 1'b0;
        lead_ok            = (i_state.pending == utf8d_pkg::PEND_NONE);
        o_result           = '0;
        if (!i_state.err) begin
            case (i_byte) inside
                [8'h00:8'h7F]: begin
                    if (!lead_ok) begin
                        bad = 1'b1;
                    end else begin
                        n_st.partial = utf8d_pkg::CP_W'(i_byte);
                    end
                end
                [8'h80:8'hBF]: begin
                    if (lead_ok) begin
                        bad = 1'b1;
                    end else begin
                        n_st.partial = {i_state.partial[utf8d_pkg::CP_W-7:0],
                                        i_byte[5:0] & utf8d_pkg::CONT_MASK[5:0]};
                        n_st.pending = i_state.pending - utf8d_pkg::PEND_ONE;
                    end
                end
                [8'hC0:8'hDF]: begin
                    if (!lead_ok) begin
                        bad = 1'b1;
                    end else begin
                        n_st.partial = utf8d_pkg::CP_W'(i_byte & utf8d_pkg::LEAD2_MASK);
                        n_st.pending = utf8d_pkg::PEND_ONE;
                    end
                end
                [8'hE0:8'hEF]: begin
                    if (!lead_ok) begin
                        bad = 1'b1;
                    end else begin
                        n_st.partial = utf8d_pkg::CP_W'(i_byte & utf8d_pkg::LEAD3_MASK);
                        n_st.pending = utf8d_pkg::PEND_TWO;
                    end
                end
                [8'hF0:8'hF7]: begin
                    if (!lead_ok) begin
                        bad = 1'b1;
                    end else begin
                        n_st.partial = utf8d_pkg::CP_W'(i_byte & utf8d_pkg::LEAD4_MASK);
                        n_st.pending = utf8d_pkg::PEND_THR;
                    end
                end
                default: begin
                    bad = 1'b1;
                end
            endcase

            // The limit applies to partial values as well as complete ones.
            if (!bad && (n_st.partial > i_max_cp)) begin
                bad = 1'b1;
            end

            if (bad) begin
                n_st.err = 1'b1;
            end else if (n_st.pending == utf8d_pkg::PEND_NONE) begin
                o_result.point_valid = 1'b1;
                o_result.code_point  = n_st.partial;
            end
        end

        // A line that stops with continuation bytes still owed is malformed.
        if (i_last && (n_st.pending != utf8d_pkg::PEND_NONE)) begin
            n_st.err = 1'b1;
        end

        o_result.error_flag = n_st.err;

        if (i_last) begin
            n_st = '0;
        end
        o_state = n_st;
    end

endmodule

`default_nettype wire

@@ rtl/core/utf8_stream_decoder_core.sv @@
// UTF-8 byte stream decoder.
// The slave side takes one byte of a text line per request in s_axis_tdata, with
// s_axis_tlast on the final byte of the line. The master side returns exactly one
// result per byte: the code point in m_axis_tdata (zero unless a point completed),
// m_axis_tuser[0] set when the byte completed a well-formed code point and
// m_axis_tuser[1] set once the line is known to be malformed. m_axis_tlast copies
// the last-byte flag; all decoder state clears after that byte.
// A byte accepted into the input register is decoded combinationally between the input
// register and the result register, and its result is presented from the result register.
// One byte per cycle is sustained while the receiver takes results: the only loop is the
// update of the pending count, partial value and error flag.
// The user must write the largest accepted code point through i_cfg_wr_en/i_cfg_wr_data only
// while the stream is idle, unenforced here; reset sets it to 0x10FFFF and clears line state.
// When the receiver stalls, the result register holds and the input register
// fills; s_axis_tready then drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [utf8d_pkg::CP_W-1:0]   i_cfg_wr_data,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,  // [7:0] byte_in
    input  wire logic                         s_axis_tlast,  // last_byte
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // [20:0] code_point, [23:21] zero
    output logic [1:0]                        m_axis_tuser,  // [0] point_valid, [1] error_flag
    output logic                              m_axis_tlast   // line_done
);

    logic                           r_in_valid;
    logic [utf8d_pkg::BYTE_W-1:0]   r_in_byte;
    logic                           r_in_last;
    utf8d_pkg::t_dec_state          r_state;
    logic [utf8d_pkg::CP_W-1:0]     r_max_cp;
    logic                           r_out_valid;
    utf8d_pkg::t_dec_result         r_out;
    logic                           r_out_last;

    utf8d_pkg::t_dec_state          n_state;
    utf8d_pkg::t_dec_result         n_out;

    logic                           out_free;
    logic                           advance;
    logic                           in_take;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    utf8d_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_max_cp (r_max_cp),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_max_cp    <= utf8d_pkg::MAX_CP_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_cp <= i_cfg_wr_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance) begin
            r_out      <= n_out;
            r_out_last <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.code_point};
    assign m_axis_tuser  = {r_out.error_flag, r_out.point_valid};
    assign m_axis_tlast  = r_out_last;

    // A completed code point is never reported together with the error flag.
    a_valid_not_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.point_valid |-> !r_out.error_flag)
        else $error("point_valid set together with error_flag");

    // The code point field is zero unless a point completed.
    a_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.point_valid |-> (r_out.code_point == '0))
        else $error("code_point nonzero without point_valid");

    // Decoder state is clear after the last byte of a line.
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> (r_state == '0))
        else $error("line state not cleared after last byte");

    // A point only completes when no continuation bytes are owed.
    a_valid_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_out.point_valid && !r_in_last |->
            (n_state.pending == utf8d_pkg::PEND_NONE))
        else $error("point completed with continuation bytes owed");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int BYTES_PER_PHASE = 145;
    localparam int NUM_PHASES     = 7;

    typedef struct {
        logic [utf8d_pkg::CP_W-1:0] code_point;
        logic                       point_valid;
        logic                       error_flag;
        logic                       line_done;
    } t_point_result;

    // Decoder state mirror plus the queue of results still owed by the block.
    class utf8_scoreboard;
        logic [utf8d_pkg::CP_W-1:0]   max_cp;
        logic [utf8d_pkg::PEND_W-1:0] pending;
        logic [utf8d_pkg::CP_W-1:0]   partial;
        logic                         line_err;
        t_point_result                expected_q[$];
        int                           n_errors;

        function new();
            max_cp   = utf8d_pkg::MAX_CP_RESET;
            pending  = utf8d_pkg::PEND_NONE;
            partial  = '0;
            line_err = 1'b0;
            n_errors = 0;
        endfunction

        task report(input string field, input logic [23:0] got, input logic [23:0] want);
            $display("tb: mismatch in %s: got %0h, want %0h", field, got, want);
            n_errors++;
        endtask

        function void note_byte(input logic [7:0] b, input logic last);
            t_point_result r;
            logic          bad;
            r.code_point  = '0;
            r.point_valid = 1'b0;
            if (!line_err) begin
                bad = 1'b0;
                if (b < 8'h80 || b >= 8'hC0) begin
                    // A byte that opens a new code point.
                    if (pending != utf8d_pkg::PEND_NONE) begin
                        bad = 1'b1;
                    end else if (b < 8'h80) begin
                        partial = utf8d_pkg::CP_W'(b);
                    end else if (b < 8'hE0) begin
                        partial = utf8d_pkg::CP_W'(b & utf8d_pkg::LEAD2_MASK);
                        pending = utf8d_pkg::PEND_ONE;
                    end else if (b < 8'hF0) begin
                        partial = utf8d_pkg::CP_W'(b & utf8d_pkg::LEAD3_MASK);
                        pending = utf8d_pkg::PEND_TWO;
                    end else if (b < 8'hF8) begin
                        partial = utf8d_pkg::CP_W'(b & utf8d_pkg::LEAD4_MASK);
                        pending = utf8d_pkg::PEND_THR;
                    end else begin
                        bad = 1'b1;
                    end
                end else if (pending == utf8d_pkg::PEND_NONE) begin
                    bad = 1'b1;
                end else begin
                    partial = {partial[utf8d_pkg::CP_W-7:0], b[5:0]};
                    pending = pending - utf8d_pkg::PEND_ONE;
                end
                if (!bad && partial > max_cp)
                    bad = 1'b1;
                if (bad) begin
                    line_err = 1'b1;
                end else if (pending == utf8d_pkg::PEND_NONE) begin
                    r.point_valid = 1'b1;
                    r.code_point  = partial;
                end
            end
            if (last && pending != utf8d_pkg::PEND_NONE)
                line_err = 1'b1;
            r.error_flag = line_err;
            r.line_done  = last;
            expected_q.push_back(r);
            if (last) begin
                pending  = utf8d_pkg::PEND_NONE;
                partial  = '0;
                line_err = 1'b0;
            end
        endfunction

        task check_result(input logic [23:0] data, input logic [1:0] user, input logic last);
            t_point_result r;
            if (expected_q.size() == 0) begin
                report("unexpected result", data, 24'h0);
                return;
            end
            r = expected_q.pop_front();
            if (data !== {3'b000, r.code_point})
                report("code_point", data, {3'b000, r.code_point});
            if (user[0] !== r.point_valid)
                report("point_valid", 24'(user[0]), 24'(r.point_valid));
            if (user[1] !== r.error_flag)
                report("error_flag", 24'(user[1]), 24'(r.error_flag));
            if (last !== r.line_done)
                report("line_done", 24'(last), 24'(r.line_done));
        endtask
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_wr_en = 1'b0;
    logic [utf8d_pkg::CP_W-1:0]   i_cfg_wr_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata = '0;
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [23:0]                  m_axis_tdata;
    logic [1:0]                   m_axis_tuser;
    logic                         m_axis_tlast;

    int                tx_idle_pct = 0;
    int                rx_stall_pct = 0;
    logic              hold_tog = 1'b0;
    logic              hold_seen = 1'b0;
    int                hold_left = 0;
    int                idle_cycles = 0;

    utf8_scoreboard    sb = new();

    // Directed lines, {last, byte}: ASCII extremes, 2-byte extremes, 3/4-byte maxima,
    // a value over the limit, a stray continuation, an ASCII byte inside a sequence,
    // an invalid byte, and a line that ends mid-sequence.
    logic [8:0] directed_bytes [0:24] = '{
        9'h000, 9'h17F,
        9'h0C2, 9'h080, 9'h0DF, 9'h1BF,
        9'h0EF, 9'h0BF, 9'h0BF, 9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
        9'h0F4, 9'h090, 9'h080, 9'h180,
        9'h180,
        9'h0C3, 9'h041, 9'h142,
        9'h0FF, 9'h141,
        9'h0E2, 9'h182
    };

    utf8_stream_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off whenever the main thread
    // toggles hold_tog.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_tog != hold_seen) begin
            hold_seen     <= hold_tog;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Request monitor, result checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering and wait until every result owed has been taken.
    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [utf8d_pkg::CP_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.max_cp = v;
    endtask

    task automatic push_point(ref logic [7:0] q[$], input logic [utf8d_pkg::CP_W-1:0] cp,
                              input int len);
        case (len)
            1: q.push_back({1'b0, cp[6:0]});
            2: begin
                q.push_back({3'b110, cp[10:6]});
                q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                q.push_back({4'b1110, cp[15:12]});
                q.push_back({2'b10, cp[11:6]});
                q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                q.push_back({5'b11110, cp[20:18]});
                q.push_back({2'b10, cp[17:12]});
                q.push_back({2'b10, cp[11:6]});
                q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Mostly well-formed lines with random code points (overlong forms and
    // values around the limit included); the rest are lines with one bad byte
    // inserted, lines cut off inside a sequence, and raw noise.
    task automatic make_line(ref logic [7:0] q[$]);
        int                         kind;
        int                         len;
        int                         pos;
        logic [utf8d_pkg::CP_W-1:0] cp;
        logic [7:0]                 junk;
        q.delete();
        kind = $urandom_range(99);
        repeat ($urandom_range(1, 8)) begin
            len = $urandom_range(1, 4);
            case (len)
                1: cp = utf8d_pkg::CP_W'($urandom_range(0, 32'h7F));
                2: cp = utf8d_pkg::CP_W'($urandom_range(0, 32'h7FF));
                3: cp = utf8d_pkg::CP_W'($urandom_range(0, 32'hFFFF));
                default: cp = utf8d_pkg::CP_W'($urandom_range(0, 32'h1FFFFF));
            endcase
            if ($urandom_range(9) == 0) begin
                cp  = sb.max_cp - utf8d_pkg::CP_W'(1)
                      + utf8d_pkg::CP_W'($urandom_range(0, 2));
                len = 4;
            end
            push_point(q, cp, len);
        end
        if (kind >= 90) begin
            q.delete();
            repeat ($urandom_range(1, 10))
                q.push_back(8'($urandom_range(0, 255)));
        end else if (kind >= 80) begin
            case ($urandom_range(2))
                0: junk = {2'b10, 6'($urandom)};
                1: junk = 8'($urandom_range(0, 255));
                default: junk = 8'($urandom_range(32'hF8, 32'hFF));
            endcase
            pos = $urandom_range(0, q.size());
            q.insert(pos, junk);
        end else if (kind >= 70) begin
            len = $urandom_range(2, 4);
            case (len)
                2: q.push_back({3'b110, 5'($urandom)});
                3: q.push_back({4'b1110, 4'($urandom)});
                default: q.push_back({5'b11110, 3'($urandom)});
            endcase
            repeat ($urandom_range(0, len - 2))
                q.push_back({2'b10, 6'($urandom)});
        end
    endtask

    initial begin
        logic [7:0]                 line_q[$];
        logic [utf8d_pkg::CP_W-1:0] limit_val;
        int                         sent;
        bit                         hold_done;
        hold_done = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 25; i++)
            send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_stream();
            case (p)
                1: limit_val = utf8d_pkg::CP_W'(127);
                2: limit_val = utf8d_pkg::CP_W'(21'h1FFFFF);
                3: limit_val = utf8d_pkg::CP_W'(21'h7FF);
                4: limit_val = utf8d_pkg::CP_W'($urandom_range(127, 32'h1FFFFF));
                5: limit_val = utf8d_pkg::MAX_CP_RESET;
                6: limit_val = utf8d_pkg::CP_W'(21'hFFFF);
                default: limit_val = utf8d_pkg::MAX_CP_RESET;
            endcase
            if (p != 0)
                write_limit(limit_val);
            case (p % 4)
                1: begin
                    tx_idle_pct = 73;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 73;
                end
                3: begin
                    tx_idle_pct = 24;
                    rx_stall_pct <= 24;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
            endcase
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                make_line(line_q);
                for (int i = 0; i < line_q.size(); i++)
                    send_byte(line_q[i], i == line_q.size() - 1);
                sent += line_q.size();
                // The sender keeps offering while the receiver holds off, so the
                // block fills and must stall its input.
                if (p == 0 && !hold_done && sent >= 40) begin
                    hold_tog <= ~hold_tog;
                    hold_done = 1;
                end
            end
        end

        drain_stream();
        repeat (10) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_step.sv
rtl/core/utf8_stream_decoder_core.sv
bench/tb.sv
